// ===== rtl/vdpe_pkg.sv =====
// Package: shared types, sizes and codes of the varying-delay packet emulator.
package vdpe_pkg;

  // Sizes
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned MAX_POINTS   = 4;
  localparam int unsigned NUM_POINTS   = 4;
  localparam int unsigned RESULT_LIMIT = 16;

  localparam int unsigned PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NRES_W   = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned SEG_W    = $clog2(NUM_POINTS);
  localparam int unsigned PC_W     = 3;
  localparam int unsigned RES_W    = 8;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Serial divider: dividend holds (16 x 8 bit product) plus rounding term
  localparam int unsigned DVD_W     = DELAY_W + RES_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam logic [15:0] STEP_TICKS_RESET = 16'd1000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 3'd0,
    CFG_RESOLUTION  = 3'd1,
    CFG_STEP_TICKS  = 3'd2,
    CFG_POINT_0     = 3'd3,
    CFG_POINT_1     = 3'd4,
    CFG_POINT_2     = 3'd5,
    CFG_POINT_3     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    FUNC_TICK   = 1'b0,
    FUNC_ARRIVE = 1'b1
  } func_e;

  typedef enum logic {
    KIND_RELEASE = 1'b0,
    KIND_DROP    = 1'b1
  } kind_e;

  // Channel payloads
  typedef struct packed {
    func_e                func;
    logic [HANDLE_W-1:0]  packet_handle;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [HANDLE_W-1:0]  out_handle;
    logic                 last;
  } res_item_t;

  // Queue entry
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   arrival;
  } fifo_entry_t;

  // Configuration register set
  typedef struct packed {
    logic [PC_W-1:0]                   point_count;
    logic [RES_W-1:0]                  resolution;
    logic [15:0]                       step_ticks;
    logic [NUM_POINTS-1:0][DELAY_W-1:0] points;
  } cfg_t;

  // Requests from the controller to the profile unit
  typedef struct packed {
    logic advance;
    logic recompute;
  } prof_ctrl_t;

  typedef enum logic [1:0] {
    PR_IDLE,
    PR_CLAMP,
    PR_MUL,
    PR_DIV
  } prof_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROF_WAIT,
    ST_CHECK,
    ST_EVAL,
    ST_DUE,
    ST_FINISH
  } ctl_state_e;

endpackage

// ===== rtl/vdpe_ram.sv =====
// Packet queue store: one write port, one registered read port.
module vdpe_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [vdpe_pkg::PTR_W-1:0] waddr_i,
  input  vdpe_pkg::fifo_entry_t     wdata_i,
  input  logic                      re_i,
  input  logic [vdpe_pkg::PTR_W-1:0] raddr_i,
  output vdpe_pkg::fifo_entry_t     rdata_o
);
  import vdpe_pkg::*;

  fifo_entry_t mem_q [QUEUE_DEPTH];
  fifo_entry_t rdata_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read entry, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vdpe_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module vdpe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vdpe_pkg::DVD_W-1:0] dividend_i,
  input  logic [vdpe_pkg::RES_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [vdpe_pkg::DVD_W-1:0] quotient_o
);
  import vdpe_pkg::*;

  logic                 active_q, active_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [RES_W-1:0]     rem_q, rem_d;
  logic [RES_W-1:0]     dsr_q, dsr_d;
  logic [RES_W:0]       trial;
  logic [RES_W:0]       diff;
  logic                 ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem_q, dvd_q[DVD_W-1]};
    ge       = trial >= {1'b0, dsr_q};
    diff     = trial - {1'b0, dsr_q};
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      dvd_d    = dividend_i;
      rem_d    = '0;
      dsr_d    = divisor_i;
    end else if (active_q) begin
      rem_d = ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/vdpe_profile.sv =====
// Delay profile position and interpolated current delay.
module vdpe_profile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vdpe_pkg::cfg_t               cfg_i,
  input  vdpe_pkg::prof_ctrl_t         ctrl_i,
  output logic                         busy_o,
  output logic [vdpe_pkg::DELAY_W-1:0] delay_o
);
  import vdpe_pkg::*;

  prof_state_e          state_q, state_d;
  logic [SEG_W-1:0]     seg_q, seg_d;
  logic [RES_W-1:0]     sub_q, sub_d;
  logic [DELAY_W-1:0]   delay_q, delay_d;
  logic [DELAY_W-1:0]   base_q, base_d;
  logic                 up_q, up_d;

  logic [PC_W-1:0]      pc_eff;
  logic [RES_W-1:0]     res_eff;
  logic [RES_W:0]       sub_inc;
  logic [PC_W-1:0]      seg_inc;
  logic [SEG_W-1:0]     seg_nxt;
  logic [DELAY_W-1:0]   pa, pb, mag;
  logic [DELAY_W+RES_W-1:0] prod;
  logic [DVD_W-1:0]     dividend;
  logic                 div_start, div_done;
  logic [DVD_W-1:0]     quotient;

  vdpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (res_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Effective register values
  always_comb begin
    if (cfg_i.point_count == '0) begin
      pc_eff = PC_W'(1);
    end else if (cfg_i.point_count > PC_W'(MAX_POINTS)) begin
      pc_eff = PC_W'(MAX_POINTS);
    end else begin
      pc_eff = cfg_i.point_count;
    end
    res_eff = (cfg_i.resolution == '0) ? RES_W'(1) : cfg_i.resolution;
  end

  // Segment operands: endpoints, span and scaled numerator
  always_comb begin
    seg_inc  = PC_W'(seg_q) + PC_W'(1);
    seg_nxt  = (seg_inc >= pc_eff) ? '0 : seg_inc[SEG_W-1:0];
    pa       = cfg_i.points[seg_q];
    pb       = cfg_i.points[seg_nxt];
    up_d     = pb >= pa;
    mag      = up_d ? (pb - pa) : (pa - pb);
    prod     = mag * sub_q;
    dividend = up_d ? DVD_W'(prod)
                    : DVD_W'(prod) + DVD_W'(res_eff) - DVD_W'(1);
    sub_inc  = {1'b0, sub_q} + 1'b1;
  end

  // Sequence: step (on advance only), clamp, multiply, divide
  always_comb begin
    state_d   = state_q;
    seg_d     = seg_q;
    sub_d     = sub_q;
    delay_d   = delay_q;
    base_d    = base_q;
    div_start = 1'b0;
    if (ctrl_i.advance) begin
      if (sub_inc >= {1'b0, res_eff}) begin
        sub_d = '0;
        seg_d = (seg_inc >= pc_eff) ? '0 : seg_inc[SEG_W-1:0];
      end else begin
        sub_d = sub_inc[RES_W-1:0];
      end
      state_d = PR_CLAMP;
    end else if (ctrl_i.recompute) begin
      state_d = PR_CLAMP;
    end else begin
      case (state_q)
        PR_IDLE: ;
        PR_CLAMP: begin
          if (PC_W'(seg_q) >= pc_eff) begin
            seg_d = '0;
          end
          if (sub_q >= res_eff) begin
            sub_d = '0;
          end
          state_d = PR_MUL;
        end
        PR_MUL: begin
          base_d    = pa;
          div_start = 1'b1;
          state_d   = PR_DIV;
        end
        PR_DIV: begin
          if (div_done) begin
            delay_d = up_q ? (base_q + quotient[DELAY_W-1:0])
                           : (base_q - quotient[DELAY_W-1:0]);
            state_d = PR_IDLE;
          end
        end
        default: state_d = PR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PR_IDLE;
      seg_q   <= '0;
      sub_q   <= '0;
      delay_q <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      sub_q   <= sub_d;
      delay_q <= delay_d;
    end
  end

  // Hold segment base and direction for the divide
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    if (state_q == PR_MUL) begin
      up_q <= up_d;
    end
  end

  assign busy_o  = state_q != PR_IDLE;
  assign delay_o = delay_q;

endmodule

// ===== rtl/varying_delay_packet_emulator.sv =====
// Top level: varying-delay packet emulator with queue store and release control.
//
//  channel   signals                           handshake
//  --------  --------------------------------  ------------------------------
//  item in   start_i, busy_o, item_i           taken when start_i && !busy_o
//  result    res_valid_o, res_o                one cycle per result, no stall
//  config    cfg_we_i, cfg_idx_i, cfg_data_i   written when cfg_we_i is high
//
// A tick or arrival keeps busy_o high while the queue head is checked and each
// due packet is released. A tick that advances the profile also waits for the
// 25-step serial divider in the profile unit; a register write to a valid index
// keeps busy_o high while the delay is recomputed. The last result of an item
// shows in the first cycle after busy_o falls. Reset clears all control state;
// the queue store is not cleared. Results cannot be stalled.
module varying_delay_packet_emulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  vdpe_pkg::in_item_t             item_i,
  output logic                           res_valid_o,
  output vdpe_pkg::res_item_t            res_o,
  input  logic                           cfg_we_i,
  input  logic [vdpe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vdpe_pkg::CFG_W-1:0]     cfg_data_i
);
  import vdpe_pkg::*;

  ctl_state_e          state_q, state_d;
  cfg_t                cfg_q, cfg_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [15:0]         tis_q, tis_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [NRES_W-1:0]   nres_q, nres_d;
  logic                head_act_q, head_act_d;
  logic [TIME_W-1:0]   hrt_q, hrt_d;
  logic                pend_vld_q, pend_vld_d;
  res_item_t           pend_q, pend_d;
  logic                res_vld_q, res_vld_d;
  res_item_t           res_q, res_d;

  prof_ctrl_t          prof_ctrl;
  logic                prof_advance;
  logic                prof_recompute;
  logic                prof_busy;
  logic [DELAY_W-1:0]  cur_delay;
  logic                accept;
  logic                mem_we, mem_re;
  fifo_entry_t         mem_wdata, mem_rdata;
  logic [15:0]         st_eff;
  logic [15:0]         tis_inc;
  logic [TIME_W-1:0]   target, tdiff, hdiff;
  logic                new_res;
  res_item_t           new_item;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  vdpe_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  vdpe_profile u_profile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctrl_i  (prof_ctrl),
    .busy_o  (prof_busy),
    .delay_o (cur_delay)
  );

  assign busy_o    = (state_q != ST_IDLE) || prof_busy;
  assign accept    = start_i && !busy_o;
  assign prof_ctrl = '{advance: prof_advance, recompute: prof_recompute};

  // Register writes; a valid index triggers a delay recompute
  always_comb begin
    cfg_d          = cfg_q;
    prof_recompute = 1'b0;
    if (cfg_we_i) begin
      prof_recompute = 1'b1;
      case (cfg_idx_i)
        CFG_POINT_COUNT: cfg_d.point_count = cfg_data_i[PC_W-1:0];
        CFG_RESOLUTION:  cfg_d.resolution  = cfg_data_i[RES_W-1:0];
        CFG_STEP_TICKS:  cfg_d.step_ticks  = cfg_data_i;
        CFG_POINT_0:     cfg_d.points[0]   = cfg_data_i;
        CFG_POINT_1:     cfg_d.points[1]   = cfg_data_i;
        CFG_POINT_2:     cfg_d.points[2]   = cfg_data_i;
        CFG_POINT_3:     cfg_d.points[3]   = cfg_data_i;
        default:         prof_recompute    = 1'b0;
      endcase
    end
  end

  // Release-time arithmetic
  always_comb begin
    st_eff  = (cfg_q.step_ticks == '0) ? 16'd1 : cfg_q.step_ticks;
    tis_inc = tis_q + 16'd1;
    target  = mem_rdata.arrival + TIME_W'(cur_delay);
    tdiff   = target - now_q;
    hdiff   = hrt_q - now_q;
  end

  // Item control: accept, queue, release due heads
  always_comb begin
    state_d           = state_q;
    now_d             = now_q;
    tis_d             = tis_q;
    rd_ptr_d          = rd_ptr_q;
    wr_ptr_d          = wr_ptr_q;
    count_d           = count_q;
    nres_d            = nres_q;
    head_act_d        = head_act_q;
    hrt_d             = hrt_q;
    pend_vld_d        = pend_vld_q;
    pend_d            = pend_q;
    res_vld_d         = 1'b0;
    res_d             = res_q;
    prof_advance      = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_wdata.handle  = item_i.packet_handle;
    mem_wdata.arrival = now_q;
    new_res           = 1'b0;
    new_item.kind     = KIND_RELEASE;
    new_item.out_handle = mem_rdata.handle;
    new_item.last     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          nres_d = '0;
          if (item_i.func == FUNC_TICK) begin
            now_d = now_q + 1'b1;
            if (tis_inc >= st_eff) begin
              tis_d        = '0;
              prof_advance = 1'b1;
              state_d      = ST_PROF_WAIT;
            end else begin
              tis_d   = tis_inc;
              state_d = ST_CHECK;
            end
          end else begin
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              new_res             = 1'b1;
              new_item.kind       = KIND_DROP;
              new_item.out_handle = item_i.packet_handle;
              nres_d              = NRES_W'(1);
            end else begin
              mem_we   = 1'b1;
              wr_ptr_d = ptr_next(wr_ptr_q);
              count_d  = count_q + 1'b1;
            end
            state_d = ST_CHECK;
          end
        end
      end
      ST_PROF_WAIT: begin
        if (!prof_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (count_q == '0 || nres_q == NRES_W'(RESULT_LIMIT)) begin
          state_d = ST_FINISH;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!head_act_q) begin
          head_act_d = 1'b1;
          hrt_d      = tdiff[TIME_W-1] ? now_q : target;
        end
        state_d = ST_DUE;
      end
      ST_DUE: begin
        if (hdiff == '0 || hdiff[TIME_W-1]) begin
          new_res    = 1'b1;
          nres_d     = nres_q + 1'b1;
          rd_ptr_d   = ptr_next(rd_ptr_q);
          count_d    = count_q - 1'b1;
          head_act_d = 1'b0;
          state_d    = ST_CHECK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (pend_vld_q) begin
          res_vld_d  = 1'b1;
          res_d      = pend_q;
          res_d.last = 1'b1;
          pend_vld_d = 1'b0;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // Hold each result until the next one shows whether it is the last
    if (new_res) begin
      if (pend_vld_q) begin
        res_vld_d = 1'b1;
        res_d     = pend_q;
      end
      pend_vld_d = 1'b1;
      pend_d     = new_item;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= ST_IDLE;
      cfg_q.point_count    <= PC_W'(1);
      cfg_q.resolution     <= RES_W'(1);
      cfg_q.step_ticks     <= STEP_TICKS_RESET;
      cfg_q.points         <= '0;
      now_q                <= '0;
      tis_q                <= '0;
      rd_ptr_q             <= '0;
      wr_ptr_q             <= '0;
      count_q              <= '0;
      nres_q               <= '0;
      head_act_q           <= 1'b0;
      hrt_q                <= '0;
      pend_vld_q           <= 1'b0;
      res_vld_q            <= 1'b0;
    end else begin
      state_q              <= state_d;
      cfg_q                <= cfg_d;
      now_q                <= now_d;
      tis_q                <= tis_d;
      rd_ptr_q             <= rd_ptr_d;
      wr_ptr_q             <= wr_ptr_d;
      count_q              <= count_d;
      nres_q               <= nres_d;
      head_act_q           <= head_act_d;
      hrt_q                <= hrt_d;
      pend_vld_q           <= pend_vld_d;
      res_vld_q            <= res_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ===== dv/delay_release_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts released and dropped packets of the emulator and compares each result.
module delay_release_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  vdpe_pkg::in_item_t             item_i,
  input  logic                           res_valid_i,
  input  vdpe_pkg::res_item_t            res_i,
  input  logic                           cfg_we_i,
  input  logic [vdpe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vdpe_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    outstanding_o
);
  import vdpe_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Register copy
  logic [PC_W-1:0]    reg_points_used;
  logic [RES_W-1:0]   reg_resolution;
  logic [15:0]        reg_step_ticks;
  logic [DELAY_W-1:0] reg_point [NUM_POINTS];

  // Profile and clock state
  logic [TIME_W-1:0]  now_q;
  logic [15:0]        tick_cnt;
  logic [SEG_W-1:0]   seg_q;
  logic [RES_W-1:0]   sub_q;
  logic [DELAY_W-1:0] delay_q;

  // Packet queue
  logic [HANDLE_W-1:0] q_handle  [QUEUE_DEPTH];
  logic [TIME_W-1:0]   q_arrival [QUEUE_DEPTH];
  int unsigned         q_rd;
  int unsigned         q_cnt;
  logic                head_armed;
  logic [TIME_W-1:0]   head_due;

  res_item_t   pending_results_q[$];
  int unsigned fail_total;

  function automatic int unsigned points_in_use();
    if (reg_points_used == 0) return 1;
    if (reg_points_used > MAX_POINTS) return MAX_POINTS;
    return reg_points_used;
  endfunction

  function automatic int unsigned steps_per_segment();
    return (reg_resolution == 0) ? 1 : reg_resolution;
  endfunction

  // Clamp the profile position, then interpolate the current delay
  task automatic refresh_delay();
    int unsigned pc;
    int unsigned res;
    int unsigned nxt;
    int unsigned a;
    int unsigned b;
    int unsigned num;
    int unsigned d;
    pc  = points_in_use();
    res = steps_per_segment();
    if (seg_q >= pc) seg_q = '0;
    if (sub_q >= res) sub_q = '0;
    nxt = int'(seg_q) + 1;
    if (nxt >= pc) nxt = 0;
    a = reg_point[seg_q];
    b = reg_point[nxt];
    if (b >= a) begin
      d = a + ((b - a) * sub_q) / res;
    end else begin
      num = (a - b) * sub_q;
      d = a - (num + res - 1) / res;
    end
    delay_q = d[DELAY_W-1:0];
  endtask

  // Move one sub-step along the profile, wrapping to point zero
  task automatic advance_profile();
    sub_q = sub_q + 1'b1;
    if (sub_q >= steps_per_segment()) begin
      sub_q = '0;
      if (int'(seg_q) + 1 >= points_in_use()) seg_q = '0;
      else seg_q = seg_q + 1'b1;
    end
    refresh_delay();
  endtask

  task automatic reset_model();
    reg_points_used = 3'd1;
    reg_resolution  = 8'd1;
    reg_step_ticks  = STEP_TICKS_RESET;
    foreach (reg_point[i]) reg_point[i] = '0;
    now_q      = '0;
    tick_cnt   = '0;
    seg_q      = '0;
    sub_q      = '0;
    q_rd       = 0;
    q_cnt      = 0;
    head_armed = 1'b0;
    head_due   = '0;
    refresh_delay();
  endtask

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_POINT_COUNT: reg_points_used = data[PC_W-1:0];
      CFG_RESOLUTION:  reg_resolution  = data[RES_W-1:0];
      CFG_STEP_TICKS:  reg_step_ticks  = data[15:0];
      CFG_POINT_0:     reg_point[0]    = data[DELAY_W-1:0];
      CFG_POINT_1:     reg_point[1]    = data[DELAY_W-1:0];
      CFG_POINT_2:     reg_point[2]    = data[DELAY_W-1:0];
      CFG_POINT_3:     reg_point[3]    = data[DELAY_W-1:0];
      default:         return;
    endcase
    refresh_delay();
  endtask

  // Release due heads in order, up to the per-item result limit
  task automatic release_due_heads(ref res_item_t made[$]);
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] gap;
    res_item_t         r;
    while (q_cnt != 0 && made.size() < RESULT_LIMIT) begin
      if (!head_armed) begin
        target     = q_arrival[q_rd] + TIME_W'(delay_q);
        gap        = target - now_q;
        head_due   = gap[TIME_W-1] ? now_q : target;
        head_armed = 1'b1;
      end
      gap = head_due - now_q;
      if (gap != 0 && !gap[TIME_W-1]) break;
      r.kind       = KIND_RELEASE;
      r.out_handle = q_handle[q_rd];
      r.last       = 1'b0;
      made = {made, r};
      q_rd       = (q_rd == QUEUE_DEPTH - 1) ? 0 : q_rd + 1;
      q_cnt      = q_cnt - 1;
      head_armed = 1'b0;
    end
  endtask

  // Work out the results that one accepted item causes
  task automatic predict_release(in_item_t it);
    res_item_t   made[$];
    res_item_t   r;
    int unsigned st;
    int unsigned wr;
    if (it.func == FUNC_TICK) begin
      st = (reg_step_ticks == 0) ? 1 : reg_step_ticks;
      now_q    = now_q + 1'b1;
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= st) begin
        tick_cnt = '0;
        advance_profile();
      end
    end else if (q_cnt >= QUEUE_DEPTH) begin
      r.kind       = KIND_DROP;
      r.out_handle = it.packet_handle;
      r.last       = 1'b0;
      made = {made, r};
    end else begin
      wr = q_rd + q_cnt;
      if (wr >= QUEUE_DEPTH) wr = wr - QUEUE_DEPTH;
      q_handle[wr]  = it.packet_handle;
      q_arrival[wr] = now_q;
      q_cnt         = q_cnt + 1;
    end
    release_due_heads(made);
    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    foreach (made[i]) pending_results_q = {pending_results_q, made[i]};
  endtask

  task automatic compare_result(res_item_t got);
    res_item_t want;
    if (pending_results_q.size() == 0) begin
      fail_total = fail_total + 1;
      if (fail_total <= REPORT_LIMIT)
        $display("unexpected result: kind %0d handle %h last %0d",
                 got.kind, got.out_handle, got.last);
      return;
    end
    want = pending_results_q.pop_front();
    if (got.kind !== want.kind || got.out_handle !== want.out_handle ||
        got.last !== want.last) begin
      fail_total = fail_total + 1;
      if (fail_total <= REPORT_LIMIT)
        $display("result mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                 want.kind, want.out_handle, want.last,
                 got.kind, got.out_handle, got.last);
    end
  endtask

  // Watch the channels: register writes, accepted items, results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      pending_results_q.delete();
      fail_total = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (res_valid_i) compare_result(res_i);
      if (start_i && !busy_i) predict_release(item_i);
      fail_count_o  <= fail_total;
      outstanding_o <= pending_results_q.size();
    end
  end

endmodule

// ===== dv/varying_delay_packet_emulator_test.sv =====
`timescale 1ns / 1ps
// Testbench top: stimulus, register phases and verdict for the varying-delay packet emulator.
module varying_delay_packet_emulator_test;
  import vdpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  in_item_t             item_i;
  logic                 res_valid_o;
  res_item_t            res_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_cnt;
  int unsigned idle_pct;

  varying_delay_packet_emulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  delay_release_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .item_i        (item_i),
    .res_valid_i   (res_valid_o),
    .res_i         (res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold the item channel, then wait until all results are in and the block is idle
  task automatic wait_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Offer one item after an optional gap and hold it until taken
  task automatic send_item(func_e f, logic [HANDLE_W-1:0] h);
    in_item_t it;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    it.func          = f;
    it.packet_handle = h;
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic random_profile();
    int unsigned r;
    write_reg(CFG_POINT_COUNT, CFG_W'($urandom_range(0, 7)));
    r = $urandom_range(0, 9);
    if (r == 0) write_reg(CFG_RESOLUTION, '0);
    else if (r == 1) write_reg(CFG_RESOLUTION, CFG_W'(255));
    else write_reg(CFG_RESOLUTION, CFG_W'($urandom_range(1, 8)));
    r = $urandom_range(0, 9);
    if (r == 0) write_reg(CFG_STEP_TICKS, '0);
    else if (r == 1) write_reg(CFG_STEP_TICKS, 16'hFFFF);
    else write_reg(CFG_STEP_TICKS, CFG_W'($urandom_range(1, 5)));
    write_reg(CFG_POINT_0, CFG_W'($urandom_range(0, 24)));
    write_reg(CFG_POINT_1, CFG_W'($urandom_range(0, 24)));
    write_reg(CFG_POINT_2, CFG_W'($urandom_range(0, 24)));
    write_reg(CFG_POINT_3, CFG_W'($urandom_range(0, 24)));
    // Unused index: the block must ignore it
    write_reg(CFG_SPARE_IDX, CFG_W'($urandom()));
  endtask

  // Runs of ticks and arrivals, with the odd burst that overflows the queue
  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned r;
    int unsigned run;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        run = $urandom_range(1, 8);
        repeat (run) send_item(FUNC_TICK, HANDLE_W'($urandom()));
      end else if (r < 9) begin
        run = $urandom_range(1, 5);
        repeat (run) send_item(FUNC_ARRIVE, HANDLE_W'($urandom()));
      end else begin
        run = QUEUE_DEPTH + 2;
        repeat (run) send_item(FUNC_ARRIVE, HANDLE_W'($urandom()));
      end
      sent = sent + run;
    end
  endtask

  initial begin
    int unsigned idle_modes [4];
    idle_modes = '{0, 54, 0, 7};
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    cycle_cnt  = 0;
    idle_pct   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();

    // Zero delay in an empty queue: each arrival leaves at once
    send_item(FUNC_ARRIVE, 16'h0000);
    send_item(FUNC_ARRIVE, 16'hFFFF);
    send_item(FUNC_TICK, 16'h0000);
    wait_quiet();

    // Fill the queue at one instant, overflow it, then release all at once
    write_reg(CFG_POINT_0, CFG_W'(5));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_item(FUNC_ARRIVE, (i % 2) ? ~HANDLE_W'(i * 16'h0F0F) : HANDLE_W'(i * 16'h0F0F));
    repeat (5) send_item(FUNC_TICK, 16'hFFFF);

    // Random profiles under the idle modes in turn
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      idle_pct = idle_modes[ph % 4];
      random_profile();
      random_traffic(PHASE_ITEMS);
    end

    // Extreme profile: full-scale swing, finest steps, fastest advance
    wait_quiet();
    idle_pct = idle_modes[3];
    write_reg(CFG_POINT_COUNT, CFG_W'(2));
    write_reg(CFG_RESOLUTION, CFG_W'(255));
    write_reg(CFG_STEP_TICKS, CFG_W'(1));
    write_reg(CFG_POINT_0, 16'hFFFF);
    write_reg(CFG_POINT_1, 16'h0000);
    write_reg(CFG_POINT_2, 16'hFFFF);
    write_reg(CFG_POINT_3, 16'h0000);
    random_traffic(40);
    wait_quiet();
    write_reg(CFG_STEP_TICKS, 16'hFFFF);
    write_reg(CFG_POINT_COUNT, CFG_W'(4));
    random_traffic(10);

    // Drain and give the verdict
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
